>>> rtl/core/cqk_pkg.sv
// Shared types and codes for the character queue core.
// Operation codes, status codes, state encoding and the result record.
// No dependencies.
package cqk_pkg;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_INSERT = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 7;
  localparam int POS_W   = 7;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_DEL  = 6'b000100,
    S_INS  = 6'b001000,
    S_WAIT = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;
    logic [CHAR_W-1:0]  out_char;
  } result_t;

endpackage

>>> rtl/core/cqk_out_reg.sv
// Output register for the character queue core: holds one result item.
// Depends on cqk_pkg for the result record.
module cqk_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  cqk_pkg::result_t res,
  output logic            free,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [23:0]     out_tdata   // out_char[7:0], entry_count[14:8], status[16:15]
);

  logic             valid_r;
  logic             valid_nxt;
  cqk_pkg::result_t data_r;

  assign free      = !valid_r || out_tready;
  assign valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {7'd0, data_r.status, data_r.entry_count, data_r.out_char};

endmodule

>>> rtl/core/char_queue_key_delete_insert_core.sv
// Top level of the character queue core: control sequencer and entry store.
// Depends on cqk_pkg and cqk_out_reg.
//
// One item is worked at a time. Push, clear, refused and ignored operations
// pass through the execute and response states to the result register; pop
// and read add a wait state for the store read. Delete by key walks the whole
// queue; insert shifts the entries from the position to the tail. The walk is
// bound by the single read port and single write port of the entry store, one
// entry per cycle. Once the result sits in the output register the input is
// ready again; a stalled output register holds the sequencer until it frees.
module char_queue_key_delete_insert_core #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // operation[2:0], char_value[10:3], position[17:11]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // out_char[7:0], entry_count[14:8], status[16:15]
);

  localparam int AW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int PW = (CW > cqk_pkg::POS_W) ? CW : cqk_pkg::POS_W;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] lidx);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(lidx);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  cqk_pkg::state_t              state_r, state_nxt;
  logic [AW-1:0]                head_r, head_nxt;
  logic [CW-1:0]                occ_r, occ_nxt;
  logic [2:0]                   op_r, op_nxt;
  logic [cqk_pkg::CHAR_W-1:0]   ch_r, ch_nxt;
  logic [cqk_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [CW-1:0]                rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]                wr_idx_r, wr_idx_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic [cqk_pkg::CHAR_W-1:0]   res_char_r, res_char_nxt;
  logic [1:0]                   res_stat_r, res_stat_nxt;

  logic [cqk_pkg::CHAR_W-1:0]   mem [QUEUE_DEPTH];
  logic [cqk_pkg::CHAR_W-1:0]   rdata_r;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [cqk_pkg::CHAR_W-1:0]   wr_data;

  logic [PW-1:0]                pos_w, occ_w, rdi_w;
  logic [CW-1:0]                pos_l;
  logic                         full, empty;
  logic                         out_free, out_load;
  cqk_pkg::result_t             res;

  assign pos_w = PW'(pos_r);
  assign occ_w = PW'(occ_r);
  assign rdi_w = PW'(rd_idx_r);
  assign pos_l = pos_w[CW-1:0];
  assign full  = (occ_r == CW'(QUEUE_DEPTH));
  assign empty = (occ_r == '0);

  assign in_tready = (state_r == cqk_pkg::S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    occ_nxt      = occ_r;
    op_nxt       = op_r;
    ch_nxt       = ch_r;
    pos_nxt      = pos_r;
    rd_idx_nxt   = rd_idx_r;
    wr_idx_nxt   = wr_idx_r;
    rd_vld_nxt   = 1'b0;
    res_char_nxt = res_char_r;
    res_stat_nxt = res_stat_r;
    rd_en        = 1'b0;
    rd_addr      = head_r;
    wr_en        = 1'b0;
    wr_addr      = head_r;
    wr_data      = ch_r;
    out_load     = 1'b0;

    case (state_r)
      cqk_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt       = in_tdata[2:0];
          ch_nxt       = in_tdata[10:3];
          pos_nxt      = in_tdata[17:11];
          res_char_nxt = '0;
          res_stat_nxt = cqk_pkg::ST_OK;
          state_nxt    = cqk_pkg::S_EXEC;
        end
      end
      cqk_pkg::S_EXEC: begin
        state_nxt = cqk_pkg::S_RESP;
        case (op_r)
          cqk_pkg::OP_PUSH: begin
            if (full) begin
              res_stat_nxt = cqk_pkg::ST_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = phys(head_r, occ_r);
              occ_nxt = occ_r + CW'(1);
            end
          end
          cqk_pkg::OP_POP: begin
            if (empty) begin
              res_stat_nxt = cqk_pkg::ST_EMPTY;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = head_r;
              head_nxt  = phys(head_r, CW'(1));
              occ_nxt   = occ_r - CW'(1);
              state_nxt = cqk_pkg::S_WAIT;
            end
          end
          cqk_pkg::OP_DELETE: begin
            rd_idx_nxt = '0;
            wr_idx_nxt = '0;
            state_nxt  = cqk_pkg::S_DEL;
          end
          cqk_pkg::OP_INSERT: begin
            if (full) begin
              res_stat_nxt = cqk_pkg::ST_FULL;
            end else if (pos_w == '0 || pos_w > occ_w) begin
              res_stat_nxt = cqk_pkg::ST_RANGE;
            end else begin
              rd_idx_nxt = occ_r;
              state_nxt  = cqk_pkg::S_INS;
            end
          end
          cqk_pkg::OP_CLEAR: begin
            head_nxt = '0;
            occ_nxt  = '0;
          end
          cqk_pkg::OP_READ: begin
            if (empty) begin
              res_stat_nxt = cqk_pkg::ST_EMPTY;
            end else if (pos_w >= occ_w) begin
              res_stat_nxt = cqk_pkg::ST_RANGE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = phys(head_r, pos_l);
              state_nxt = cqk_pkg::S_WAIT;
            end
          end
          default: begin
          end
        endcase
      end
      cqk_pkg::S_DEL: begin
        if (rd_idx_r != occ_r) begin
          rd_en      = 1'b1;
          rd_addr    = phys(head_r, rd_idx_r);
          rd_idx_nxt = rd_idx_r + CW'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          if (rdata_r != ch_r) begin
            wr_en      = 1'b1;
            wr_addr    = phys(head_r, wr_idx_r);
            wr_data    = rdata_r;
            wr_idx_nxt = wr_idx_r + CW'(1);
          end
        end else if (rd_idx_r == occ_r) begin
          occ_nxt   = wr_idx_r;
          state_nxt = cqk_pkg::S_RESP;
        end
      end
      cqk_pkg::S_INS: begin
        if (rdi_w >= pos_w) begin
          rd_en      = 1'b1;
          rd_addr    = phys(head_r, rd_idx_r - CW'(1));
          wr_idx_nxt = rd_idx_r;
          rd_idx_nxt = rd_idx_r - CW'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = phys(head_r, wr_idx_r);
          wr_data = rdata_r;
        end else if (rdi_w < pos_w) begin
          wr_en     = 1'b1;
          wr_addr   = phys(head_r, rd_idx_r);
          wr_data   = ch_r;
          occ_nxt   = occ_r + CW'(1);
          state_nxt = cqk_pkg::S_RESP;
        end
      end
      cqk_pkg::S_WAIT: begin
        res_char_nxt = rdata_r;
        state_nxt    = cqk_pkg::S_RESP;
      end
      cqk_pkg::S_RESP: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = cqk_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cqk_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cqk_pkg::S_IDLE;
      head_r   <= '0;
      occ_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      occ_r    <= occ_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    ch_r       <= ch_nxt;
    pos_r      <= pos_nxt;
    rd_idx_r   <= rd_idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    res_char_r <= res_char_nxt;
    res_stat_r <= res_stat_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign res.out_char    = res_char_r;
  assign res.entry_count = occ_w[cqk_pkg::COUNT_W-1:0];
  assign res.status      = res_stat_r;

  cqk_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same entry");

  a_del_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cqk_pkg::S_DEL && rd_vld_r) |-> (wr_idx_r < rd_idx_r))
    else $error("compaction write overtook the read pointer");

  a_wait_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cqk_pkg::S_WAIT) |-> $past(rd_en))
    else $error("result capture without a store read");

endmodule

>>> verif/testbench.sv
// Self-checking bench for char_queue_key_delete_insert_core: directed and random operations.
// A clocked driver and monitor, a circular-store predictor and a random ready pattern.
// Depends on cqk_pkg and the core RTL.
module testbench;

  localparam int DEPTH = 64;
  localparam int ITEM_TARGET = 1650;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 80;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam int PH_FILL  = 0;
  localparam int PH_DRAIN = 1;
  localparam int PH_MIXED = 2;

  localparam int RX_OPEN    = 0;
  localparam int RX_PATTERN = 1;
  localparam int RX_RANDOM  = 2;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
    logic [6:0] pos;
    bit         drain;
  } queue_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;  // operation[2:0], char_value[10:3], position[17:11]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;      // out_char[7:0], entry_count[14:8], status[16:15]

  queue_req_t  stim_items [$];
  logic [7:0]  gen_contents [$];
  int          live_items = 0;

  cqk_pkg::result_t pending_results [$];
  logic [7:0]  mirror_store [DEPTH];
  int unsigned mirror_head = 0;
  int unsigned mirror_count = 0;
  int unsigned peak_count = 0;

  queue_req_t  cur_item;
  int          gap_left = 0;
  int          burst_left = 1;
  int unsigned items_taken = 0;
  int unsigned results_done = 0;
  int          mismatch_count = 0;
  int          op_seen [8];
  int          status_seen [4];

  int          rx_mode = RX_OPEN;
  logic [7:0]  rx_pattern = 8'hFF;
  logic [7:0]  rx_tick = 8'd0;
  int          cycle_count = 0;
  logic [7:0]  hot_chars [4];

  char_queue_key_delete_insert_core #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  task automatic apply_queue_op(input queue_req_t req, output cqk_pkg::result_t res);
    int unsigned i;
    int unsigned j;
    logic [7:0]  v;
    res = '0;
    res.status = cqk_pkg::ST_OK;
    case (req.op)
      cqk_pkg::OP_PUSH: begin
        if (mirror_count >= DEPTH) begin
          res.status = cqk_pkg::ST_FULL;
        end else begin
          mirror_store[(mirror_head + mirror_count) % DEPTH] = req.ch;
          mirror_count++;
        end
      end
      cqk_pkg::OP_POP: begin
        if (mirror_count == 0) begin
          res.status = cqk_pkg::ST_EMPTY;
        end else begin
          res.out_char = mirror_store[mirror_head];
          mirror_head = (mirror_head + 1) % DEPTH;
          mirror_count--;
        end
      end
      cqk_pkg::OP_DELETE: begin
        j = 0;
        for (i = 0; i < mirror_count; i++) begin
          v = mirror_store[(mirror_head + i) % DEPTH];
          if (v != req.ch) begin
            mirror_store[(mirror_head + j) % DEPTH] = v;
            j++;
          end
        end
        mirror_count = j;
      end
      cqk_pkg::OP_INSERT: begin
        if (mirror_count >= DEPTH) begin
          res.status = cqk_pkg::ST_FULL;
        end else if (req.pos < 1 || req.pos > mirror_count) begin
          res.status = cqk_pkg::ST_RANGE;
        end else begin
          for (i = mirror_count; i > req.pos - 1; i--)
            mirror_store[(mirror_head + i) % DEPTH] =
              mirror_store[(mirror_head + i - 1) % DEPTH];
          mirror_store[(mirror_head + req.pos - 1) % DEPTH] = req.ch;
          mirror_count++;
        end
      end
      cqk_pkg::OP_CLEAR: begin
        mirror_head = 0;
        mirror_count = 0;
      end
      cqk_pkg::OP_READ: begin
        if (mirror_count == 0)
          res.status = cqk_pkg::ST_EMPTY;
        else if (req.pos >= mirror_count)
          res.status = cqk_pkg::ST_RANGE;
        else
          res.out_char = mirror_store[(mirror_head + req.pos) % DEPTH];
      end
      default: ;
    endcase
    res.entry_count = mirror_count[cqk_pkg::COUNT_W-1:0];
    if (mirror_count > peak_count)
      peak_count = mirror_count;
  endtask

  // Track the queue contents at generation time so that positions and keys hit live entries.
  task automatic enqueue_req(input logic [2:0] op, input logic [7:0] ch, input logic [6:0] pos,
                             input bit drain);
    queue_req_t r;
    int         i;
    r.op = op;
    r.ch = ch;
    r.pos = pos;
    r.drain = drain;
    stim_items.push_back(r);
    case (op)
      cqk_pkg::OP_PUSH:
        if (gen_contents.size() < DEPTH) gen_contents.push_back(ch);
      cqk_pkg::OP_POP:
        if (gen_contents.size() != 0) void'(gen_contents.pop_front());
      cqk_pkg::OP_DELETE:
        for (i = gen_contents.size() - 1; i >= 0; i--)
          if (gen_contents[i] == ch) gen_contents.delete(i);
      cqk_pkg::OP_INSERT:
        if (gen_contents.size() < DEPTH && pos >= 1 && pos <= gen_contents.size())
          gen_contents.insert(pos - 1, ch);
      cqk_pkg::OP_CLEAR:
        gen_contents.delete();
      default: ;
    endcase
    if (op <= cqk_pkg::OP_READ)
      live_items++;
  endtask

  always @(posedge clk) begin : drive_items
    cqk_pkg::result_t want;
    logic        load;
    int unsigned taken;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      taken = items_taken;
      if (in_tvalid && in_tready) begin
        apply_queue_op(cur_item, want);
        pending_results.push_back(want);
        op_seen[cur_item.op]++;
        taken++;
        items_taken <= taken;
      end
      if (!in_tvalid || in_tready) begin
        load = 1'b0;
        if (gap_left != 0)
          gap_left--;
        else if (stim_items.size() != 0 && (!stim_items[0].drain || taken == results_done))
          load = 1'b1;
        if (load) begin
          cur_item = stim_items.pop_front();
          in_tdata <= {6'd0, cur_item.pos, cur_item.ch, cur_item.op};
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_tvalid <= load;
      end
    end
  end

  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (rx_tick == 8'd0) begin
        rx_mode = $urandom_range(RX_OPEN, RX_RANDOM);
        rx_pattern = 8'($urandom_range(0, 255)) | 8'h01;
      end
      rx_tick = rx_tick + 8'd1;
      case (rx_mode)
        RX_OPEN:    out_tready <= 1'b1;
        RX_PATTERN: out_tready <= rx_pattern[rx_tick[2:0]];
        default:    out_tready <= ($urandom_range(0, 2) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    cqk_pkg::result_t got;
    cqk_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[16:0];
      results_done <= results_done + 1;
      status_seen[got.status]++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no item outstanding", results_done));
      end else begin
        want = pending_results.pop_front();
        if (got.out_char !== want.out_char)
          report_mismatch($sformatf("result %0d out_char %02h, expected %02h",
                                    results_done, got.out_char, want.out_char));
        if (got.entry_count !== want.entry_count)
          report_mismatch($sformatf("result %0d entry_count %0d, expected %0d",
                                    results_done, got.entry_count, want.entry_count));
        if (got.status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    results_done, got.status, want.status));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : run_test
    int         kind;
    int         span;
    int         phase_no;
    int         k;
    int         r;
    int         sz;
    logic [2:0] op;
    logic [7:0] ch;
    logic [6:0] pos;

    for (k = 0; k < DEPTH; k++) mirror_store[k] = 8'h00;
    for (k = 0; k < 8; k++) op_seen[k] = 0;
    for (k = 0; k < 4; k++) status_seen[k] = 0;
    hot_chars[0] = 8'h00;
    hot_chars[1] = 8'hFF;
    hot_chars[2] = 8'h41;
    hot_chars[3] = 8'h42;

    // empty queue, ignored codes, then a small queue with duplicates
    enqueue_req(cqk_pkg::OP_POP,    8'h00, 7'd0,   1'b0);
    enqueue_req(cqk_pkg::OP_READ,   8'h00, 7'd0,   1'b0);
    enqueue_req(cqk_pkg::OP_INSERT, 8'h11, 7'd1,   1'b0);
    enqueue_req(cqk_pkg::OP_DELETE, 8'h00, 7'd0,   1'b0);
    enqueue_req(OP_SPARE_A,         8'hFF, 7'd127, 1'b0);
    enqueue_req(OP_SPARE_B,         8'h00, 7'd0,   1'b0);
    enqueue_req(cqk_pkg::OP_CLEAR,  8'hFF, 7'd127, 1'b0);
    enqueue_req(cqk_pkg::OP_PUSH,   8'h00, 7'd0,   1'b0);
    enqueue_req(cqk_pkg::OP_PUSH,   8'hFF, 7'd127, 1'b0);
    enqueue_req(cqk_pkg::OP_PUSH,   8'hA5, 7'd0,   1'b0);
    enqueue_req(cqk_pkg::OP_PUSH,   8'hFF, 7'd0,   1'b0);
    enqueue_req(cqk_pkg::OP_READ,   8'h00, 7'd0,   1'b0);
    enqueue_req(cqk_pkg::OP_READ,   8'h00, 7'd3,   1'b0);
    enqueue_req(cqk_pkg::OP_READ,   8'h00, 7'd4,   1'b0);
    enqueue_req(cqk_pkg::OP_READ,   8'hFF, 7'd127, 1'b0);
    enqueue_req(cqk_pkg::OP_INSERT, 8'h5A, 7'd0,   1'b0);
    enqueue_req(cqk_pkg::OP_INSERT, 8'h7E, 7'd1,   1'b0);
    enqueue_req(cqk_pkg::OP_INSERT, 8'h81, 7'd5,   1'b0);
    enqueue_req(cqk_pkg::OP_INSERT, 8'h99, 7'd7,   1'b0);
    enqueue_req(cqk_pkg::OP_DELETE, 8'hFF, 7'd0,   1'b0);
    enqueue_req(cqk_pkg::OP_DELETE, 8'h33, 7'd0,   1'b0);
    enqueue_req(cqk_pkg::OP_POP,    8'h00, 7'd0,   1'b0);
    enqueue_req(cqk_pkg::OP_CLEAR,  8'h00, 7'd0,   1'b0);
    enqueue_req(cqk_pkg::OP_READ,   8'h00, 7'd0,   1'b0);

    phase_no = 0;
    while (live_items < ITEM_TARGET) begin
      kind = $urandom_range(PH_FILL, PH_MIXED);
      span = (kind == PH_FILL) ? $urandom_range(60, 140) : $urandom_range(30, 90);
      for (k = 0; k < span; k++) begin
        sz = gen_contents.size();
        r = $urandom_range(0, 99);
        case (kind)
          PH_FILL:
            op = (r < 50) ? cqk_pkg::OP_PUSH : (r < 75) ? cqk_pkg::OP_INSERT :
                 (r < 85) ? cqk_pkg::OP_READ : (r < 91) ? cqk_pkg::OP_POP :
                 (r < 95) ? cqk_pkg::OP_DELETE : (r < 96) ? cqk_pkg::OP_CLEAR :
                 (r[0] ? OP_SPARE_A : OP_SPARE_B);
          PH_DRAIN:
            op = (r < 10) ? cqk_pkg::OP_PUSH : (r < 15) ? cqk_pkg::OP_INSERT :
                 (r < 30) ? cqk_pkg::OP_READ : (r < 70) ? cqk_pkg::OP_POP :
                 (r < 95) ? cqk_pkg::OP_DELETE : (r < 97) ? cqk_pkg::OP_CLEAR :
                 (r[0] ? OP_SPARE_A : OP_SPARE_B);
          default:
            op = (r < 25) ? cqk_pkg::OP_PUSH : (r < 45) ? cqk_pkg::OP_INSERT :
                 (r < 65) ? cqk_pkg::OP_READ : (r < 80) ? cqk_pkg::OP_POP :
                 (r < 92) ? cqk_pkg::OP_DELETE : (r < 95) ? cqk_pkg::OP_CLEAR :
                 (r[0] ? OP_SPARE_A : OP_SPARE_B);
        endcase
        ch = 8'($urandom_range(0, 255));
        pos = 7'($urandom_range(0, 127));
        if ($urandom_range(0, 1) == 0)
          ch = hot_chars[$urandom_range(0, 3)];
        case (op)
          cqk_pkg::OP_DELETE:
            if (kind != PH_FILL && sz != 0 && $urandom_range(0, 9) < 6)
              ch = gen_contents[$urandom_range(0, sz - 1)];
          cqk_pkg::OP_INSERT:
            if (sz != 0 && $urandom_range(0, 9) < 8) pos = 7'($urandom_range(1, sz));
          cqk_pkg::OP_READ:
            if (sz != 0 && $urandom_range(0, 9) < 8) pos = 7'($urandom_range(0, sz - 1));
          default: ;
        endcase
        // hold the first item of every fourth phase until the queue of results has emptied
        enqueue_req(op, ch, pos, (k == 0) && (phase_no % 4 == 0));
      end
      phase_no++;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_items.size() != 0 || in_tvalid || pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));

    $display("covered %0d items: push %0d, pop %0d, delete %0d, insert %0d, clear %0d,",
             items_taken, op_seen[cqk_pkg::OP_PUSH], op_seen[cqk_pkg::OP_POP],
             op_seen[cqk_pkg::OP_DELETE], op_seen[cqk_pkg::OP_INSERT],
             op_seen[cqk_pkg::OP_CLEAR]);
    $display("read %0d, ignored %0d; refusals: full %0d, empty %0d, out of range %0d; peak %0d of %0d",
             op_seen[cqk_pkg::OP_READ], op_seen[OP_SPARE_A] + op_seen[OP_SPARE_B],
             status_seen[cqk_pkg::ST_FULL], status_seen[cqk_pkg::ST_EMPTY],
             status_seen[cqk_pkg::ST_RANGE], peak_count, DEPTH);

    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
